>>> sv/cpet_pkg.sv
// shared types and constants for the collision pair event tracker
// no dependencies; imported by every module of the block except cpet_ram
`default_nettype none

package cpet_pkg;

  localparam int PAIR_COUNT  = 256;
  localparam int IDX_W       = $clog2(PAIR_COUNT);
  localparam int ID_W        = 8;
  localparam int COORD_W     = 24;
  localparam int SIZE_W      = 23;
  localparam int MAG_W       = 24;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int S_DATA_W    = 200;
  localparam int S_USER_W    = 2;
  localparam int M_DATA_W    = 8;
  localparam int M_USER_W    = 3;
  // power of two, pointers wrap naturally
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    BK_CLEAR  = 2'd0,
    BK_IDLE   = 2'd1,
    BK_LOOKUP = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [ID_W-1:0] pair;
    logic            hit;
  } cls_t;

  function automatic logic [IDX_W-1:0] slot_of(input logic [ID_W-1:0] id);
    logic [IDX_W+ID_W-1:0] wide;
    wide = {{IDX_W{1'b0}}, id};
    return wide[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/cpet_front.sv
// front end: accepts pair words, runs the overlap test in two stages
// depends on cpet_pkg; feeds cpet_queue
`default_nettype none

module cpet_front
  import cpet_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic [S_USER_W-1:0] s_tuser,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output cls_t                     q_item
);

  logic [ID_W-1:0]    pair_id;
  logic [COORD_W-1:0] left_x, left_y, right_x, right_y;
  logic [SIZE_W-1:0]  left_width, left_height, right_width, right_height;

  assign pair_id      = s_tdata[7:0];
  assign left_x       = s_tdata[31:8];
  assign left_y       = s_tdata[55:32];
  assign right_x      = s_tdata[79:56];
  assign right_y      = s_tdata[103:80];
  assign left_width   = s_tdata[126:104];
  assign left_height  = s_tdata[149:127];
  assign right_width  = s_tdata[172:150];
  assign right_height = s_tdata[195:173];

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        adx, ady;

  always_comb begin
    dx  = $signed({left_x[COORD_W-1], left_x}) - $signed({right_x[COORD_W-1], right_x});
    dy  = $signed({left_y[COORD_W-1], left_y}) - $signed({right_y[COORD_W-1], right_y});
    adx = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    ady = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
  end

  // stage 1 registers
  logic             s1_v;
  logic [ID_W-1:0]  s1_pair;
  logic [MAG_W-1:0] s1_ax, s1_ay, s1_wsum, s1_hsum;
  logic             s1_rect, s1_circ;

  // stage 2 registers
  logic             s2_v;
  logic [ID_W-1:0]  s2_pair;
  logic [SQ_W-1:0]  s2_sqx, s2_sqy, s2_sqs;
  logic             s2_rect_hit, s2_rect, s2_circ;

  logic s2_load, s1_adv;

  assign q_valid  = s2_v;
  assign s2_load  = !s2_v || q_ready;
  assign s1_adv   = s1_v && s2_load;
  assign s_tready = !s1_v || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s_tready) begin
      s1_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1_pair <= pair_id;
      s1_ax   <= adx[MAG_W-1:0];
      s1_ay   <= ady[MAG_W-1:0];
      s1_wsum <= {1'b0, left_width} + {1'b0, right_width};
      s1_hsum <= {1'b0, left_height} + {1'b0, right_height};
      s1_rect <= !s_tuser[0] && !s_tuser[1];
      s1_circ <= s_tuser[0] && s_tuser[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (s2_load) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_pair     <= s1_pair;
      s2_sqx      <= s1_ax * s1_ax;
      s2_sqy      <= s1_ay * s1_ay;
      s2_sqs      <= s1_hsum * s1_hsum;
      s2_rect_hit <= ({s1_ax, 1'b0} <= {1'b0, s1_wsum}) &&
                     ({s1_ay, 1'b0} <= {1'b0, s1_hsum});
      s2_rect     <= s1_rect;
      s2_circ     <= s1_circ;
    end
  end

  // circles: 4(dx^2 + dy^2) < (hl + hr)^2
  logic [SQ_W:0]   dist_sum;
  logic [SQ_W+2:0] dist4;
  logic            circ_hit;

  always_comb begin
    dist_sum    = {1'b0, s2_sqx} + {1'b0, s2_sqy};
    dist4       = {dist_sum, 2'b00};
    circ_hit    = dist4 < {3'b000, s2_sqs};
    q_item.pair = s2_pair;
    q_item.hit  = (s2_rect && s2_rect_hit) || (s2_circ && circ_hit);
  end

endmodule

`default_nettype wire

>>> sv/cpet_queue.sv
// short fifo of classified pair words between front and back end
// depends on cpet_pkg
`default_nettype none

module cpet_queue
  import cpet_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cls_t in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output cls_t      out_item
);

  cls_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push, pop;

  assign in_ready  = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> sv/cpet_back.sv
// back end: per-pair activity ram, event decode and output register
// depends on cpet_pkg; fed by cpet_queue; also holds the generic ram module
`default_nettype none

module cpet_back
  import cpet_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire cls_t                q_item,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,
  output logic [M_USER_W-1:0]      m_tuser
);

  back_state_t           state, state_next;
  logic [IDX_W-1:0]      clr_addr;
  cls_t                  cur;
  logic                  pop;
  logic                  load_out;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic                  ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic                  was_active;
  event_t                ev;

  logic                  out_hit;
  event_t                out_ev;
  logic [ID_W-1:0]       out_pair;

  cpet_ram #(
    .WIDTH (1),
    .DEPTH (PAIR_COUNT)
  ) u_active (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (was_active)
  );

  assign pop = q_valid && q_ready;

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    load_out   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = 1'b0;
    ram_raddr  = slot_of(cur.pair);
    case (state)
      BK_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == IDX_W'(PAIR_COUNT - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        q_ready   = 1'b1;
        ram_raddr = slot_of(q_item.pair);
        if (q_valid) begin
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          ram_we     = 1'b1;
          ram_waddr  = slot_of(cur.pair);
          ram_wdata  = cur.hit;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_CLEAR;
      end
    endcase
  end

  always_comb begin
    case ({cur.hit, was_active})
      2'b10:   ev = EV_ENTER;
      2'b11:   ev = EV_STAY;
      2'b01:   ev = EV_EXIT;
      default: ev = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_item;
    end
    if (load_out) begin
      out_hit  <= cur.hit;
      out_ev   <= ev;
      out_pair <= cur.pair;
    end
  end

  assign m_tdata = out_pair;
  assign m_tuser = {out_ev, out_hit};

endmodule

// generic simple dual-port ram, registered read
module cpet_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/collision_pair_event_tracker_core.sv
// top level of the collision pair event tracker
// depends on cpet_pkg, cpet_front, cpet_queue and cpet_back
`default_nettype none

// Takes collider pair words and returns one event word for each, in order.
// Two rectangles hit when 2|dx| <= wl+wr and 2|dy| <= hl+hr, two circles
// (height is the diameter) when 4(dx^2+dy^2) < (hl+hr)^2, mixed pairs never
// hit. A per-pair activity bit, held in a 256-entry ram, turns the hit into
// none, enter, stay or exit. After reset the back end clears the activity
// ram; meanwhile the front end takes up to six words (two test stages and
// the four-word queue) and then holds s_tready low. The back end takes one
// word at a time: in its idle state it pops a word and reads its activity
// bit from the registered ram; in its lookup state, once the output register
// is free, it decodes the event, writes the bit back and loads the output
// register. From input accept to output valid a word passes the two test
// stages, the queue and the back end lookup. The queue lets the test
// pipeline keep running for a few words while the output side stalls.

module collision_pair_event_tracker_core
  import cpet_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // pair_id, left_x, left_y, right_x, right_y, left_width, left_height,
  // right_width, right_height, zero pad
  input  wire logic [S_DATA_W-1:0] s_tdata,
  // left_is_circle, right_is_circle
  input  wire logic [S_USER_W-1:0] s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // pair_out
  output logic [M_DATA_W-1:0]      m_tdata,
  // hit, event_res
  output logic [M_USER_W-1:0]      m_tuser
);

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cls_t fq_item, qb_item;

  cpet_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_item   (fq_item)
  );

  cpet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  cpet_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_item   (qb_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for collision_pair_event_tracker_core
// depends on cpet_pkg and the core; holds its own pair activity predictor
`timescale 1ns / 100ps

module tb_top;
  import cpet_pkg::*;

  typedef struct packed {
    logic [3:0]         pad;
    logic [SIZE_W-1:0]  rh;
    logic [SIZE_W-1:0]  rw;
    logic [SIZE_W-1:0]  lh;
    logic [SIZE_W-1:0]  lw;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ly;
    logic [COORD_W-1:0] lx;
    logic [ID_W-1:0]    id;
  } geom_t;

  typedef struct {
    logic            hit;
    event_t          ev;
    logic [ID_W-1:0] pair;
  } pair_event_t;

  class event_board;
    bit          active[PAIR_COUNT];
    pair_event_t due[$];
    int          errors;

    function new();
      foreach (active[i]) active[i] = 0;
      errors = 0;
    endfunction

    function void note_pair(geom_t g, logic [S_USER_W-1:0] kinds);
      longint      ax;
      longint      ay;
      longint      sq;
      longint      sd;
      int          slot;
      pair_event_t e;
      ax = longint'($signed(g.lx)) - longint'($signed(g.rx));
      ay = longint'($signed(g.ly)) - longint'($signed(g.ry));
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (kinds == 2'b00) begin
        e.hit = (2 * ax <= longint'(g.lw) + longint'(g.rw)) &&
                (2 * ay <= longint'(g.lh) + longint'(g.rh));
      end else if (kinds == 2'b11) begin
        sq = 4 * (ax * ax + ay * ay);
        sd = longint'(g.lh) + longint'(g.rh);
        e.hit = sq < sd * sd;
      end else begin
        e.hit = 1'b0;
      end
      slot = int'(g.id) % PAIR_COUNT;
      if (e.hit) begin
        e.ev = active[slot] ? EV_STAY : EV_ENTER;
        active[slot] = 1;
      end else if (active[slot]) begin
        e.ev = EV_EXIT;
        active[slot] = 0;
      end else begin
        e.ev = EV_NONE;
      end
      e.pair = g.id;
      due.push_back(e);
    endfunction

    function void check_event(logic [M_DATA_W-1:0] d, logic [M_USER_W-1:0] u);
      pair_event_t e;
      if (due.size() == 0) begin
        $error("event word with no pair pending: pair_out %0d", d);
        errors++;
        return;
      end
      e = due.pop_front();
      if (u[0] !== e.hit) begin
        $error("hit expected %0d actual %0d", e.hit, u[0]);
        errors++;
      end
      if (u[2:1] !== e.ev) begin
        $error("event_res expected %0d actual %0d", e.ev, u[2:1]);
        errors++;
      end
      if (d !== e.pair) begin
        $error("pair_out expected %0d actual %0d", e.pair, d);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  bit         calm_in = 0;
  bit         calm_out = 0;
  event_board board = new();

  collision_pair_event_tracker_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_pair(geom_t'(s_tdata), s_tuser);
    if (!rst && m_tvalid && m_tready) board.check_event(m_tdata, m_tuser);
  end

  function automatic geom_t geom(int id, int lx, int ly, int rx, int ry,
                                 int lw, int lh, int rw, int rh);
    geom_t g;
    g.pad = '0;
    g.id  = ID_W'(id);
    g.lx  = COORD_W'(lx);
    g.ly  = COORD_W'(ly);
    g.rx  = COORD_W'(rx);
    g.ry  = COORD_W'(ry);
    g.lw  = SIZE_W'(lw);
    g.lh  = SIZE_W'(lh);
    g.rw  = SIZE_W'(rw);
    g.rh  = SIZE_W'(rh);
    return g;
  endfunction

  task automatic send_pair(geom_t g, logic [S_USER_W-1:0] kinds);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= g;
    s_tuser  <= kinds;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // output side stalls
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    geom_t          g;
    logic [1:0]     kinds;
    int             sel;
    int             dx;
    int             dy;
    int             k;
    int             sd;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero-size rectangles on equal centres, then stay, then mixed kinds
    send_pair(geom(0, 0, 0, 0, 0, 0, 0, 0, 0), 2'b00);
    send_pair(geom(0, 0, 0, 0, 0, 0, 0, 0, 0), 2'b00);
    send_pair(geom(0, 0, 0, 0, 0, 100, 100, 100, 100), 2'b01);
    send_pair(geom(0, 0, 0, 0, 0, 100, 100, 100, 100), 2'b10);
    // zero-diameter circles never hit
    send_pair(geom(1, 0, 0, 0, 0, 0, 0, 0, 0), 2'b11);
    // rectangle edges touching, then one step apart
    send_pair(geom(2, 0, 0, 100, 0, 100, 10, 100, 10), 2'b00);
    send_pair(geom(2, 0, 0, 101, 0, 100, 10, 100, 10), 2'b00);
    send_pair(geom(5, 7, 0, 7, 50, 0, 50, 0, 50), 2'b00);
    send_pair(geom(6, -100, -3, 100, 3, 200, 6, 200, 6), 2'b00);
    // circles exactly at the sum of radii, then just inside
    send_pair(geom(3, 0, 0, 300, 400, 0, 500, 0, 500), 2'b11);
    send_pair(geom(3, 0, 0, 300, 400, 0, 500, 0, 501), 2'b11);
    send_pair(geom(4, 9, 9, 9, 9, 0, 0, 0, 1), 2'b11);
    // coordinate and size extremes
    send_pair(geom(255, -8388608, -8388608, 8388607, 8388607,
                   8388607, 8388607, 8388607, 8388607), 2'b00);
    send_pair(geom(255, -8388608, -8388608, -8388608, -8388608,
                   8388607, 8388607, 8388607, 8388607), 2'b00);
    send_pair(geom(254, -8388608, -8388608, 8388607, 8388607,
                   8388607, 8388607, 8388607, 8388607), 2'b11);
    send_pair(geom(254, 8388607, 8388607, 8388607, 8388607,
                   8388607, 8388607, 8388607, 8388607), 2'b11);
    send_pair(geom(255, 8388607, -8388608, 8388607, -8388608, 0, 0, 0, 0), 2'b00);
    send_pair(geom(128, 1, 1, 2, 2, 4, 4, 4, 4), 2'b00);
    send_pair(geom(128, 1, 1, 2, 2, 4, 4, 4, 4), 2'b11);
    send_pair(geom(128, 1, 1, 200, 2, 4, 4, 4, 4), 2'b11);

    for (int n = 0; n < 1050; n++) begin
      if (n % 100 == 0) begin
        calm_in  = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
      end
      sel = $urandom_range(0, 9);
      kinds = (sel < 4) ? 2'b00 : (sel < 8) ? 2'b11 : 2'($urandom_range(1, 2));
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        // noise over the full field ranges
        g = geom_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom()});
        g.pad = '0;
        kinds = 2'($urandom());
      end else begin
        g.pad = '0;
        g.id  = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 7))
                                           : ID_W'($urandom());
        g.lx  = COORD_W'($urandom());
        g.ly  = COORD_W'($urandom());
        if (sel < 30 && kinds == 2'b11) begin
          // circle pair right at the sum of radii
          k  = $urandom_range(1, 100000);
          dx = 3 * k;
          dy = 4 * k;
          if ($urandom_range(0, 1)) begin
            dx = 4 * k;
            dy = 3 * k;
          end
          sd = 10 * k - 1 + $urandom_range(0, 2);
          g.lw = SIZE_W'($urandom());
          g.rw = SIZE_W'($urandom());
          g.lh = SIZE_W'($urandom_range(0, sd));
          g.rh = SIZE_W'(sd - int'(g.lh));
        end else if (sel < 30) begin
          // rectangle pair right at touching edges
          g.lw = SIZE_W'($urandom_range(0, 4194303));
          g.rw = SIZE_W'($urandom_range(0, 4194303));
          g.lh = SIZE_W'($urandom_range(0, 4194303));
          g.rh = SIZE_W'($urandom_range(0, 4194303));
          dx = (int'(g.lw) + int'(g.rw)) / 2 + $urandom_range(0, 1);
          dy = (int'(g.lh) + int'(g.rh)) / 2 - $urandom_range(0, 1);
          if ($urandom_range(0, 1)) begin
            k  = dx;
            dx = dy;
            dy = k;
          end
        end else begin
          g.lw = SIZE_W'($urandom_range(0, 4095));
          g.lh = SIZE_W'($urandom_range(0, 4095));
          g.rw = SIZE_W'($urandom_range(0, 4095));
          g.rh = SIZE_W'($urandom_range(0, 4095));
          dx = $urandom_range(0, 4095);
          dy = $urandom_range(0, 4095);
        end
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        g.rx = g.lx + COORD_W'(dx);
        g.ry = g.ly + COORD_W'(dy);
      end
      send_pair(g, kinds);
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
